@@ hw/rtl/iparl_pkg.sv @@
// ----------------------------------------------------------------------------
// iparl_pkg
// Shared types and constants of the IPv4 admission rate limiter.
// ----------------------------------------------------------------------------
package iparl_pkg;

  localparam int HistorySets = 256;
  localparam int HistoryWays = 4;
  localparam int AclEntries  = 4;
  localparam int SetBits     = $clog2(HistorySets);
  localparam int WayBits     = $clog2(HistoryWays);
  localparam int SlotBits    = (AclEntries > 1) ? $clog2(AclEntries) : 1;
  localparam int CountBits   = $clog2(HistoryWays + 1);

  localparam logic [7:0]  FloodLimitReset    = 8'd10;
  localparam logic [29:0] FloodIntervalReset = 30'd3000;
  localparam logic [30:0] FloodReleaseReset  = 31'd600000;
  localparam logic [7:0]  CountMax           = 8'hFF;

  localparam logic [1:0] RegFloodLimit    = 2'd0;
  localparam logic [1:0] RegFloodInterval = 2'd1;
  localparam logic [1:0] RegFloodRelease  = 2'd2;

  localparam logic [2:0] CmdCheck   = 3'd0;
  localparam logic [2:0] CmdLockout = 3'd1;
  localparam logic [2:0] CmdAge     = 3'd2;
  localparam logic [2:0] CmdAllow   = 3'd3;
  localparam logic [2:0] CmdDeny    = 3'd4;

  localparam logic [1:0] VerdictReject = 2'd0;
  localparam logic [1:0] VerdictAccept = 2'd1;
  localparam logic [1:0] VerdictUncond = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [31:0] now_tick;
    logic [7:0]  set_index;
    logic [1:0]  acl_slot;
    logic [31:0] acl_mask;
    logic        acl_enable;
  } req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       flood_detected;
    logic       table_full;
    logic [2:0] entries_seen;
    logic [2:0] entries_removed;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        address;
    logic [31:0]        now_tick;
    logic [SetBits-1:0] set_sel;
    logic               set_ok;
    logic [1:0]         acl_verdict;
  } job_t;

  // signed 32-bit difference, widened
  function automatic logic signed [32:0] tick_age(input logic [31:0] now,
                                                  input logic [31:0] then_tick);
    logic [31:0] d;
    d = now - then_tick;
    return {d[31], d};
  endfunction

endpackage

@@ hw/rtl/iparl_front.sv @@
// ----------------------------------------------------------------------------
// iparl_front
// Accepts requests, owns the allow and deny tables and classifies checks.
// ----------------------------------------------------------------------------
module iparl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  iparl_pkg::req_t   in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output iparl_pkg::job_t   job
);
  import iparl_pkg::*;

  logic [31:0] allow_address [AclEntries];
  logic [31:0] allow_mask    [AclEntries];
  logic        allow_active  [AclEntries];
  logic [31:0] deny_address  [AclEntries];
  logic [31:0] deny_mask     [AclEntries];
  logic        deny_active   [AclEntries];

  logic allow_hit, deny_hit, take, slot_ok;
  logic [SlotBits-1:0] slot;

  assign in_ready = !job_valid || job_ready;
  assign take     = in_valid && in_ready;
  assign slot     = SlotBits'(in_data.acl_slot);
  assign slot_ok  = {30'd0, in_data.acl_slot} < AclEntries;

  always_comb begin
    allow_hit = 1'b0;
    deny_hit  = 1'b0;
    for (int i = 0; i < AclEntries; i++) begin
      if (allow_active[i] &&
          ((in_data.address & allow_mask[i]) == (allow_address[i] & allow_mask[i])))
        allow_hit = 1'b1;
      if (deny_active[i] &&
          ((in_data.address & deny_mask[i]) == (deny_address[i] & deny_mask[i])))
        deny_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      for (int i = 0; i < AclEntries; i++) begin
        allow_address[i] <= '0;
        allow_mask[i]    <= '0;
        allow_active[i]  <= 1'b0;
        deny_address[i]  <= '0;
        deny_mask[i]     <= '0;
        deny_active[i]   <= 1'b0;
      end
    end else begin
      if (take) begin
        job_valid       <= 1'b1;
        job.command     <= in_data.command;
        job.address     <= in_data.address;
        job.now_tick    <= in_data.now_tick;
        job.set_sel     <= (in_data.command == CmdAge) ? SetBits'(in_data.set_index)
                                                       : SetBits'(in_data.address);
        job.set_ok      <= (in_data.command != CmdAge) ||
                           ({24'd0, in_data.set_index} < HistorySets);
        job.acl_verdict <= deny_hit ? VerdictReject :
                           allow_hit ? VerdictUncond : VerdictAccept;
        if (slot_ok && in_data.command == CmdAllow) begin
          allow_address[slot] <= in_data.address;
          allow_mask[slot]    <= in_data.acl_mask;
          allow_active[slot]  <= in_data.acl_enable;
        end
        if (slot_ok && in_data.command == CmdDeny) begin
          deny_address[slot] <= in_data.address;
          deny_mask[slot]    <= in_data.acl_mask;
          deny_active[slot]  <= in_data.acl_enable;
        end
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/iparl_back.sv @@
// ----------------------------------------------------------------------------
// iparl_back
// History store engine: reads one set, decides, writes back, reports.
// ----------------------------------------------------------------------------
module iparl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  iparl_pkg::job_t   job,
  input  logic [7:0]        flood_limit,
  input  logic [29:0]       flood_interval_ms,
  input  logic [30:0]       flood_release_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output iparl_pkg::rsp_t   out_data
);
  import iparl_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_WRITE, S_OUT} state_t;
  typedef struct packed {
    logic [31:0] address;
    logic [31:0] tick;
    logic [7:0]  count;
    logic        flooding;
  } ent_t;
  localparam int RowBits = $bits(ent_t) * HistoryWays;

  state_t state;
  job_t   cur;
  logic [SetBits-1:0] clr_ptr;
  logic [HistoryWays-1:0] vmem [HistorySets];
  logic [RowBits-1:0]     dmem [HistorySets];
  logic [HistoryWays-1:0] rd_v;
  logic [RowBits-1:0]     rd_d;
  logic [HistoryWays-1:0] wr_v;
  logic [RowBits-1:0]     wr_d;
  logic [SetBits-1:0]     wr_set;
  logic                   wr_en;
  rsp_t                   res;

  ent_t ents [HistoryWays];
  ent_t ents_next [HistoryWays];
  logic [HistoryWays-1:0] v_next;
  rsp_t res_next;

  // combinational decision over the registered row
  always_comb begin
    logic hit, placed;
    logic [WayBits-1:0] hw;
    logic signed [32:0] age;
    logic signed [33:0] stale;
    logic [CountBits-1:0] seen, removed;
    hit = 1'b0; placed = 1'b0; hw = '0; age = '0;
    seen = '0; removed = '0;
    stale = 34'(flood_interval_ms) * 34'sd3;
    res_next = '0;
    v_next = rd_v;
    for (int w = 0; w < HistoryWays; w++) begin
      ents[w] = rd_d[w*$bits(ent_t) +: $bits(ent_t)];
      ents_next[w] = ents[w];
    end
    for (int w = HistoryWays - 1; w >= 0; w--)
      if (rd_v[w] && ents[w].address == cur.address) begin
        hit = 1'b1;
        hw  = WayBits'(w);
      end
    case (cur.command)
      CmdCheck: begin
        res_next.verdict = cur.acl_verdict;
        if (hit) begin
          age = tick_age(cur.now_tick, ents[hw].tick);
          if (ents[hw].flooding) begin
            res_next.verdict = (cur.acl_verdict == VerdictUncond) ? VerdictAccept
                                                                  : VerdictReject;
          end else if (age < $signed({3'b000, flood_interval_ms})) begin
            ents_next[hw].tick  = cur.now_tick;
            ents_next[hw].count = (ents[hw].count == CountMax) ? CountMax
                                                                : ents[hw].count + 8'd1;
            if (ents[hw].count >= flood_limit) begin
              ents_next[hw].flooding = 1'b1;
              res_next.flood_detected = 1'b1;
              res_next.verdict = (cur.acl_verdict == VerdictUncond) ? VerdictAccept
                                                                    : VerdictReject;
            end
          end else begin
            ents_next[hw].tick  = cur.now_tick;
            ents_next[hw].count = '0;
          end
        end else begin
          for (int w = 0; w < HistoryWays; w++)
            if (!placed && !rd_v[w]) begin
              placed = 1'b1;
              v_next[w] = 1'b1;
              ents_next[w] = '{cur.address, cur.now_tick, 8'd0, 1'b0};
            end
          res_next.table_full = !placed;
        end
      end
      CmdLockout: begin
        if (hit) begin
          ents_next[hw].flooding = 1'b1;
          ents_next[hw].tick     = cur.now_tick;
        end else begin
          for (int w = 0; w < HistoryWays; w++)
            if (!placed && !rd_v[w]) begin
              placed = 1'b1;
              v_next[w] = 1'b1;
              ents_next[w] = '{cur.address, cur.now_tick, 8'd0, 1'b1};
            end
          res_next.table_full = !placed;
        end
      end
      CmdAge: begin
        if (cur.set_ok) begin
          for (int w = 0; w < HistoryWays; w++)
            if (rd_v[w]) begin
              seen = seen + CountBits'(1);
              age = tick_age(cur.now_tick, ents[w].tick);
              if ((!ents[w].flooding && 34'(age) > stale) ||
                  (ents[w].flooding && age > $signed({2'b00, flood_release_ms}))) begin
                v_next[w] = 1'b0;
                removed = removed + CountBits'(1);
              end
            end
          res_next.entries_seen    = 3'(seen);
          res_next.entries_removed = 3'(removed);
        end
      end
      default: ;
    endcase
  end

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  always_ff @(posedge clk) begin
    rd_v <= vmem[cur.set_sel];
    rd_d <= dmem[cur.set_sel];
    if (wr_en) begin
      vmem[wr_set] <= wr_v;
      dmem[wr_set] <= wr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_ptr <= '0;
      wr_en   <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      case (state)
        S_CLEAR: begin
          // one row of valid bits per cycle
          wr_en   <= 1'b1;
          wr_set  <= clr_ptr;
          wr_v    <= '0;
          clr_ptr <= clr_ptr + SetBits'(1);
          if (clr_ptr == SetBits'(HistorySets - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_READ;
          end
        end
        S_READ:   state <= S_DECIDE;
        S_DECIDE: begin
          res    <= res_next;
          wr_set <= cur.set_sel;
          wr_v   <= v_next;
          for (int w = 0; w < HistoryWays; w++)
            wr_d[w*$bits(ent_t) +: $bits(ent_t)] <= ents_next[w];
          wr_en  <= (cur.command == CmdCheck) || (cur.command == CmdLockout) ||
                    (cur.command == CmdAge && cur.set_ok);
          state  <= S_WRITE;
        end
        S_WRITE: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_hot_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !job_ready) else $error("result shown while idle");
  a_removed_le_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entries_removed <= out_data.entries_seen)
    else $error("removed more than seen");
  a_flood_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.flood_detected) |-> out_data.verdict != VerdictUncond)
    else $error("flooding address given unconditional accept");
  a_write_after_decide: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $past(state == S_DECIDE)) else $error("write out of order");

endmodule

@@ hw/rtl/ip_admission_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// ip_admission_rate_limiter
// IPv4 connection admission with allow/deny lists and a flood detector.
// ----------------------------------------------------------------------------
// After reset the history store is cleared one set per cycle, all 256 sets.
// During the clear the front takes a single request and holds it until the
// clear is done. Each request then occupies the history engine through the
// steps take, set read, decide, write back and result, set by the registered
// read and the single write port of the history memory; the result step
// lasts until the receiver takes the result. The access list front
// classifies the next request meanwhile and holds it in a one-entry queue.
module ip_admission_rate_limiter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  iparl_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output iparl_pkg::rsp_t   out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  import iparl_pkg::*;

  logic [7:0]  flood_limit;
  logic [29:0] flood_interval_ms;
  logic [30:0] flood_release_ms;
  logic        job_valid, job_ready;
  job_t        job;

  always_ff @(posedge clk) begin
    if (rst) begin
      flood_limit       <= FloodLimitReset;
      flood_interval_ms <= FloodIntervalReset;
      flood_release_ms  <= FloodReleaseReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFloodLimit:    flood_limit       <= cfg_data[7:0];
        RegFloodInterval: flood_interval_ms <= cfg_data[29:0];
        RegFloodRelease:  flood_release_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  iparl_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .job_valid, .job_ready, .job
  );

  iparl_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .flood_limit, .flood_interval_ms, .flood_release_ms,
    .out_valid, .out_ready, .out_data
  );

endmodule
